// ----- sv/pjid_pkg.sv -----
// Package for the job dispatcher: operation and status codes, cell request types.
// No dependencies.
`timescale 1ns / 1ps
package pjid_pkg;
    typedef enum logic [1:0] {
        OP_SUBMIT = 2'd0,
        OP_GRAB   = 2'd1,
        OP_FINISH = 2'd2,
        OP_UNUSED = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_ACCEPTED     = 3'd0,
        ST_REJECTED     = 3'd1,
        ST_GRANTED      = 3'd2,
        ST_EMPTY        = 3'd3,
        ST_FINISHED     = 3'd4,
        ST_COMPLETED    = 3'd5,
        ST_FINISH_ERROR = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        FSM_IDLE = 2'd0,
        FSM_SCAN = 2'd1,
        FSM_DONE = 2'd2
    } fsm_t;

    // per-cell command broadcast from the controller
    typedef struct packed {
        logic        ins;     // insert at tail
        logic        rem;     // remove entry whose slot matches
        logic        grab;    // bump grabbed count of the winning cell
        logic        fin;     // bump finished count of matching cell
    } cell_cmd_t;

    localparam int unsigned SLOT_W = 4;
    localparam int unsigned CNT_W  = 16;
    localparam int unsigned LVL_W  = 3;
endpackage

// ----- sv/pjid_cell.sv -----
// One cell of the dispatch queue: holds a queued job and its counters.
// Depends on pjid_pkg.
`timescale 1ns / 1ps
module pjid_cell
    import pjid_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  cell_cmd_t           cmd,
    input  logic                is_tail,     // first empty cell
    input  logic                win,         // this cell wins the grab
    input  logic [SLOT_W-1:0]   key_slot,
    input  logic [LVL_W-1:0]    new_level,
    input  logic [CNT_W-1:0]    new_total,
    // neighbour to the right, for shifting on removal
    input  logic                nb_valid,
    input  logic [SLOT_W-1:0]   nb_slot,
    input  logic [LVL_W-1:0]    nb_level,
    input  logic [CNT_W-1:0]    nb_total,
    input  logic [CNT_W-1:0]    nb_grab,
    input  logic [CNT_W-1:0]    nb_fin,
    input  logic                shift_in,    // a cell left of here matched
    output logic                shift_out,
    output logic                valid,
    output logic [SLOT_W-1:0]   slot,
    output logic [LVL_W-1:0]    level,
    output logic [CNT_W-1:0]    total,
    output logic [CNT_W-1:0]    grab,
    output logic [CNT_W-1:0]    fin
);
    logic              valid_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [LVL_W-1:0]  level_reg;
    logic [CNT_W-1:0]  total_reg, grab_reg, fin_reg;
    logic              hit;

    assign hit       = valid_reg && (slot_reg == key_slot);
    assign shift_out = shift_in || (cmd.rem && hit);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (cmd.rem && shift_out)
        begin
            valid_reg <= nb_valid;
        end
        else if (cmd.ins && is_tail)
        begin
            valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rem && shift_out)
        begin
            slot_reg  <= nb_slot;
            level_reg <= nb_level;
            total_reg <= nb_total;
            grab_reg  <= nb_grab;
            fin_reg   <= nb_fin;
        end
        else if (cmd.ins && is_tail)
        begin
            slot_reg  <= key_slot;
            level_reg <= new_level;
            total_reg <= new_total;
            grab_reg  <= '0;
            fin_reg   <= '0;
        end
        else
        begin
            if (cmd.grab && win)
            begin
                grab_reg <= grab_reg + 1'b1;
            end
            if (cmd.fin && hit)
            begin
                fin_reg <= fin_reg + 1'b1;
            end
        end
    end

    assign valid = valid_reg;
    assign slot  = slot_reg;
    assign level = level_reg;
    assign total = total_reg;
    assign grab  = grab_reg;
    assign fin   = fin_reg;
endmodule

// ----- sv/priority_job_instance_dispatcher.sv -----
// Top level of the priority job dispatcher: controller plus a row of queue cells.
// Depends on pjid_pkg and pjid_cell.
`timescale 1ns / 1ps
//
//  channel   | direction | handshake      | fields
//  ----------+-----------+----------------+-----------------------------------------
//  request   | in        | start & !busy  | operation job_slot priority_level
//            |           |                | instance_total long_worker
//  result    | out       | done strobe    | status granted_slot instance_index
//            |           |                | granted_total
//
//  Every request passes through accept, a scan/update state, then the
//  result strobe. All queues share one row of JOB_SLOTS cells (at most
//  16) kept in arrival order; a cell carries its level, so each queue is
//  the subsequence of its level and removal shifts the cells right of the
//  hole one place left. A grab picks the first cell (lowest index) with
//  the best eligible level. Reset clears the cell valid bits and the
//  controller; the result strobe cannot be stalled, and busy stays high
//  through the strobe cycle, so a new request is taken only back in idle.
module priority_job_instance_dispatcher
    import pjid_pkg::*;
#(
    parameter int unsigned LEVELS    = 3,
    parameter int unsigned JOB_SLOTS = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          operation,
    input  logic [SLOT_W-1:0]   job_slot,
    input  logic [LVL_W-1:0]    priority_level,
    input  logic [CNT_W-1:0]    instance_total,
    input  logic                long_worker,
    output logic                done,
    output logic [2:0]          status,
    output logic [SLOT_W-1:0]   granted_slot,
    output logic [CNT_W-1:0]    instance_index,
    output logic [CNT_W-1:0]    granted_total
);
    localparam int unsigned N = (JOB_SLOTS > 16) ? 16 : JOB_SLOTS;

    fsm_t              state_reg, state_next;
    logic [1:0]        op_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [LVL_W-1:0]  lvl_reg;
    logic [CNT_W-1:0]  tot_reg;
    logic              lw_reg;
    logic [2:0]        status_reg, status_next;
    logic [SLOT_W-1:0] gslot_reg, gslot_next;
    logic [CNT_W-1:0]  gidx_reg, gidx_next, gtot_reg, gtot_next;
    cell_cmd_t         cmd;

    logic [N-1:0]      c_valid;
    logic [SLOT_W-1:0] c_slot  [N];
    logic [LVL_W-1:0]  c_level [N];
    logic [CNT_W-1:0]  c_total [N];
    logic [CNT_W-1:0]  c_grab  [N];
    logic [CNT_W-1:0]  c_fin   [N];
    logic [N:0]        shift_chain;
    logic [N-1:0]      elig, is_tail, win_vec;

    // eligibility and tail detection per cell
    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            elig[i] = c_valid[i] && (c_grab[i] < c_total[i]) &&
                      (lw_reg ? (c_level[i] == LVL_W'(LEVELS))
                              : (c_level[i] < LVL_W'(LEVELS)));
            is_tail[i] = !c_valid[i] && ((i == 0) || c_valid[(i == 0) ? 0 : i-1]);
        end
    end

    // pick lowest level, then earliest arrival
    logic              any_win;
    logic [SLOT_W-1:0] win_i;
    logic [LVL_W-1:0]  best_lvl;
    always_comb
    begin
        any_win  = 1'b0;
        win_i    = '0;
        best_lvl = '0;
        for (int i = 0; i < N; i++)
        begin
            if (elig[i] && (!any_win || c_level[i] < best_lvl))
            begin
                any_win  = 1'b1;
                win_i    = SLOT_W'(i);
                best_lvl = c_level[i];
            end
        end
        for (int i = 0; i < N; i++)
        begin
            win_vec[i] = any_win && (win_i == SLOT_W'(i));
        end
    end

    // lookup of the addressed slot
    logic              hit_any;
    logic [CNT_W-1:0]  h_total, h_grab, h_fin;
    always_comb
    begin
        hit_any = 1'b0;
        h_total = '0;
        h_grab  = '0;
        h_fin   = '0;
        for (int i = 0; i < N; i++)
        begin
            if (c_valid[i] && c_slot[i] == slot_reg)
            begin
                hit_any = 1'b1;
                h_total = c_total[i];
                h_grab  = c_grab[i];
                h_fin   = c_fin[i];
            end
        end
    end

    assign shift_chain[0] = 1'b0;

    genvar g;
    generate
        for (g = 0; g < N; g++)
        begin : g_cell
            localparam int unsigned NB = (g + 1 < N) ? g + 1 : g;
            pjid_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .cmd       (cmd),
                .is_tail   (is_tail[g]),
                .win       (win_vec[g]),
                .key_slot  (slot_reg),
                .new_level (lvl_reg),
                .new_total (tot_reg),
                .nb_valid  ((g + 1 < N) ? c_valid[NB] : 1'b0),
                .nb_slot   (c_slot[NB]),
                .nb_level  (c_level[NB]),
                .nb_total  (c_total[NB]),
                .nb_grab   (c_grab[NB]),
                .nb_fin    (c_fin[NB]),
                .shift_in  (shift_chain[g]),
                .shift_out (shift_chain[g+1]),
                .valid     (c_valid[g]),
                .slot      (c_slot[g]),
                .level     (c_level[g]),
                .total     (c_total[g]),
                .grab      (c_grab[g]),
                .fin       (c_fin[g])
            );
        end
    endgenerate

    // hold the request, advance the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FSM_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == FSM_IDLE && start)
        begin
            op_reg   <= operation;
            slot_reg <= job_slot;
            lvl_reg  <= priority_level;
            tot_reg  <= instance_total;
            lw_reg   <= long_worker;
        end
        if (state_reg == FSM_SCAN)
        begin
            status_reg <= status_next;
            gslot_reg  <= gslot_next;
            gidx_reg   <= gidx_next;
            gtot_reg   <= gtot_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        status_next = ST_REJECTED;
        gslot_next  = slot_reg;
        gidx_next   = '0;
        gtot_next   = '0;
        case (state_reg)
            FSM_IDLE:
            begin
                if (start)
                begin
                    state_next = FSM_SCAN;
                end
            end
            FSM_SCAN:
            begin
                state_next = FSM_DONE;
                case (op_reg)
                    OP_SUBMIT:
                    begin
                        if (lvl_reg <= LVL_W'(LEVELS) && tot_reg != '0 &&
                            32'(slot_reg) < JOB_SLOTS && !hit_any && !c_valid[N-1])
                        begin
                            cmd.ins     = 1'b1;
                            status_next = ST_ACCEPTED;
                        end
                    end
                    OP_GRAB:
                    begin
                        gslot_next  = '0;
                        status_next = ST_EMPTY;
                        if (any_win)
                        begin
                            cmd.grab    = 1'b1;
                            status_next = ST_GRANTED;
                            gslot_next  = c_slot[win_i[$clog2(N)-1:0]];
                            gidx_next   = c_grab[win_i[$clog2(N)-1:0]];
                            gtot_next   = c_total[win_i[$clog2(N)-1:0]];
                        end
                    end
                    OP_FINISH:
                    begin
                        status_next = ST_FINISH_ERROR;
                        if (hit_any && h_fin < h_grab)
                        begin
                            cmd.fin     = 1'b1;
                            status_next = ST_FINISHED;
                            if (h_fin + 1'b1 == h_total)
                            begin
                                cmd.fin     = 1'b0;
                                cmd.rem     = 1'b1;
                                status_next = ST_COMPLETED;
                            end
                        end
                    end
                    default:
                    begin
                        status_next = ST_REJECTED;
                    end
                endcase
            end
            FSM_DONE:
            begin
                state_next = FSM_IDLE;
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    assign busy           = (state_reg != FSM_IDLE);
    assign done           = (state_reg == FSM_DONE);
    assign status         = status_reg;
    assign granted_slot   = gslot_reg;
    assign instance_index = gidx_reg;
    assign granted_total  = gtot_reg;

    // valid cells stay packed at the low end
    for (g = 1; g < N; g++)
    begin : g_chk
        a_packed: assert property (@(posedge clk) disable iff (!rst_n)
            c_valid[g] |-> c_valid[g-1])
            else $error("queue cells not packed");
    end

    a_done_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == FSM_SCAN))
        else $error("result without scan");

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.ins, cmd.rem, cmd.grab, cmd.fin}))
        else $error("conflicting cell commands");

    a_grant_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_GRANTED) |-> (instance_index < granted_total))
        else $error("grant beyond instance count");
endmodule
